FILE: hw/rtl/gde_pkg.sv
// shared types and constants for the gravity and drag euler step core
`default_nettype none
package gde_pkg;

  localparam int DEF_MAX_BODIES = 16;
  localparam int DEF_FRAC_BITS  = 16;

  // working width of the shared arithmetic unit
  localparam int UW = 128;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic REG_BODIES = 1'b0;
  localparam logic REG_GRAV   = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [3:0]         body_index;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic [31:0]        mass;
    logic [30:0]        radius;
    logic [30:0]        atmos_radius;
    logic [31:0]        drag_coeff;
    logic [23:0]        time_step;
    logic               last_ship;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_position_x;
    logic signed [31:0] new_position_y;
    logic signed [31:0] new_velocity_x;
    logic signed [31:0] new_velocity_y;
    logic               saturated;
    logic               frame_end;
  } result_t;

  typedef struct packed {
    logic        index;
    logic [31:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] mass;
    logic [30:0] radius;
    logic [30:0] atmos;
    logic [31:0] drag;
  } body_t;

  typedef enum logic [2:0] {
    AR_MUL  = 3'b001,
    AR_DIV  = 3'b010,
    AR_SQRT = 3'b100
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
    logic [7:0] steps;
  } arith_req_t;

  typedef struct packed {
    logic          done;
    logic [UW-1:0] value;
  } arith_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gde_stream_if.sv
// valid/ready channel carrying one payload beat
`default_nettype none
interface gde_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/gde_ram.sv
// generic single write port ram with registered read
`default_nettype none
module gde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/gde_arith.sv
// shared bit-serial multiply, divide and square root unit
`default_nettype none
module gde_arith
  import gde_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire arith_req_t    req,
  input  wire logic [UW-1:0] opa,
  input  wire logic [UW-1:0] opb,
  output arith_rsp_t         rsp
);
  arith_op_t     op_r;
  logic          busy;
  logic          done;
  logic [7:0]    cnt;
  logic [UW-1:0] acc;
  logic [UW-1:0] x;
  logic [UW-1:0] y;

  logic [UW-1:0] add_a;
  logic [UW-1:0] add_b;
  logic          sub;
  logic [UW:0]   sum;
  logic          ge;
  logic [7:0]    sh_div;
  logic [7:0]    sh_sqrt;

  always_comb begin
    add_a = acc;
    add_b = x;
    sub   = 1'b0;
    unique case (op_r)
      AR_MUL: begin
        add_a = acc;
        add_b = x;
        sub   = 1'b0;
      end
      AR_DIV: begin
        add_a = {acc[UW-2:0], y[UW-1]};
        add_b = x;
        sub   = 1'b1;
      end
      AR_SQRT: begin
        add_a = {acc[UW-3:0], y[UW-1:UW-2]};
        add_b = {x[UW-3:0], 2'b01};
        sub   = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + (UW+1)'(sub);
    // carry out on a subtract means no borrow
    ge  = sum[UW];
  end

  assign sh_div  = 8'(UW) - req.steps;
  assign sh_sqrt = 8'(UW) - {req.steps[6:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= AR_MUL;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op_r <= req.op;
        cnt  <= req.steps;
        acc  <= '0;
        unique case (req.op)
          AR_MUL: begin
            x <= opa;
            y <= opb;
          end
          AR_DIV: begin
            x <= opb;
            y <= opa << sh_div;
          end
          AR_SQRT: begin
            x <= '0;
            y <= opa << sh_sqrt;
          end
          default: begin
            x <= '0;
            y <= '0;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        unique case (op_r)
          AR_MUL: begin
            if (y[0]) acc <= sum[UW-1:0];
            x <= x << 1;
            y <= y >> 1;
          end
          AR_DIV: begin
            acc <= ge ? sum[UW-1:0] : add_a;
            y   <= {y[UW-2:0], ge};
          end
          AR_SQRT: begin
            acc <= ge ? sum[UW-1:0] : add_a;
            x   <= {x[UW-2:0], ge};
            y   <= y << 2;
          end
          default: begin
            acc <= acc;
          end
        endcase
      end
    end
  end

  always_comb begin
    rsp.done = done;
    unique case (op_r)
      AR_MUL:  rsp.value = acc;
      AR_DIV:  rsp.value = y;
      AR_SQRT: rsp.value = x;
      default: rsp.value = '0;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/gravity_drag_euler_step_core.sv
// top level: body table, step sequencer and output register
//
//  channel | role  | beat
//  item    | sink  | body load or ship step (item_t)
//  result  | source| updated ship state (result_t), one per ship step
//  cfg     | sink  | register write: index 0 bodies in use, 1 gravity constant
//
// a body load is written straight into the table; a ship step runs all its multiplies,
// divides and square roots for the n bodies in use and any drag term, one at a time,
// in the one bit-serial arithmetic unit (one bit or root digit a cycle)
// a body sitting exactly on the ship skips its gravity terms and costs less
// rst is synchronous; it clears the sequencer, registers and output valid, not the table
// a finished result waits in the output register; the next item is taken meanwhile
`default_nettype none
module gravity_drag_euler_step_core
  import gde_pkg::*;
#(
  parameter int MAX_BODIES = DEF_MAX_BODIES,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input wire logic   clk,
  input wire logic   rst,
  gde_stream_if.sink   item,
  gde_stream_if.source result,
  gde_stream_if.sink   cfg
);
  localparam int IW  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW  = $clog2(MAX_BODIES + 1);
  localparam int XW  = (IW > 4) ? IW : 4;
  localparam int GMW = 64 + FRAC_BITS;
  localparam logic [7:0] STEP_MAG = 8'(64 + FRAC_BITS);
  localparam logic [7:0] STEP_QUO = 8'(97 + FRAC_BITS);
  localparam logic [60:0] ACC_LIM = 61'h1000_0000_0000_0000;
  localparam logic [40:0] DV_LIM  = 41'h100_0000_0000;

  typedef enum logic [31:0] {
    S_IDLE = 32'h0000_0001, S_RD   = 32'h0000_0002, S_DIFF = 32'h0000_0004,
    S_SQX  = 32'h0000_0008, S_SQY  = 32'h0000_0010, S_ATM  = 32'h0000_0020,
    S_BRD  = 32'h0000_0040, S_SQRT = 32'h0000_0080, S_GM   = 32'h0000_0100,
    S_DD   = 32'h0000_0200, S_MAG  = 32'h0000_0400, S_MX   = 32'h0000_0800,
    S_QX   = 32'h0000_1000, S_MY   = 32'h0000_2000, S_QY   = 32'h0000_4000,
    S_NEXT = 32'h0000_8000, S_DRAG = 32'h0001_0000, S_V2X  = 32'h0002_0000,
    S_V2Y  = 32'h0004_0000, S_SPD  = 32'h0008_0000, S_KX1  = 32'h0010_0000,
    S_KX2  = 32'h0020_0000, S_KX3  = 32'h0040_0000, S_KY1  = 32'h0080_0000,
    S_KY2  = 32'h0100_0000, S_KY3  = 32'h0200_0000, S_DVX  = 32'h0400_0000,
    S_SVX  = 32'h0800_0000, S_SVY  = 32'h1000_0000, S_SPX  = 32'h2000_0000,
    S_SPY  = 32'h4000_0000, S_OUT  = 32'h8000_0000
  } state_t;

  function automatic logic [60:0] clip60(input logic [UW-1:0] v);
    return (v > UW'(ACC_LIM)) ? ACC_LIM : v[60:0];
  endfunction

  function automatic logic signed [61:0] acc_add(input logic signed [61:0] a,
                                                 input logic [60:0] m, input logic neg);
    logic signed [61:0] t;
    logic signed [62:0] s;
    t = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    s = 63'(a) + 63'(t);
    if (s > $signed({2'b00, ACC_LIM})) return $signed({1'b0, ACC_LIM});
    else if (s < -$signed({2'b00, ACC_LIM})) return -$signed({1'b0, ACC_LIM});
    else return s[61:0];
  endfunction

  // add a time-scaled step to a 32-bit value, saturating; returns {clipped, value}
  function automatic logic [32:0] step_add(input logic signed [31:0] base,
                                           input logic [UW-1:0] prod, input logic neg);
    logic [UW-1:0]      sh;
    logic [40:0]        m;
    logic signed [42:0] t;
    logic signed [42:0] s;
    sh = prod >> FRAC_BITS;
    m  = (sh > UW'(DV_LIM)) ? DV_LIM : sh[40:0];
    t  = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    s  = 43'(base) + t;
    if (s > 43'sd2147483647) return {1'b1, 32'h7fff_ffff};
    else if (s < -43'sd2147483648) return {1'b1, 32'h8000_0000};
    else return {1'b0, s[31:0]};
  endfunction

  state_t state;

  logic [4:0]  bodies_in_use;
  logic [31:0] grav_const;

  logic [CW-1:0]      i;
  logic [CW-1:0]      n_use;
  logic signed [31:0] sx, sy, vx, vy;
  logic [31:0]        ms;
  logic [30:0]        sr;
  logic [23:0]        dt;
  logic               last;
  logic [32:0]        adx, ady;
  logic               dxneg, dyneg;
  logic [65:0]        d2;
  logic [63:0]        atm2;
  logic [33:0]        d;
  logic [GMW-1:0]     gm;
  logic [GMW-1:0]     mag;
  logic [63:0]        v2;
  logic [31:0]        spd;
  logic               found;
  logic [31:0]        dk;
  logic signed [61:0] ax, ay;
  logic               flag;

  result_t res_q;
  logic    res_valid;

  body_t          rd_body;
  logic           we;
  logic [XW-1:0]  widx;
  logic [32:0]    dx_c, dy_c;
  logic [32:0]    adx_c, ady_c;
  logic [31:0]    sa;
  logic [31:0]    avx, avy;
  logic [60:0]    amx, amy;
  logic [31:0]    vxa, vya;
  logic [55:0]    den;
  logic [32:0]    upd;

  arith_req_t    req;
  arith_rsp_t    rsp;
  logic [UW-1:0] opa, opb;

  assign item.ready   = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;
  assign result.data  = res_q;

  assign n_use = (32'(bodies_in_use) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(bodies_in_use);
  assign widx  = XW'(item.data.body_index);
  assign we    = item.valid && item.ready && (item.data.operation == OP_LOAD) &&
                 (32'(item.data.body_index) < MAX_BODIES);

  gde_ram #(
    .WIDTH ($bits(body_t)),
    .DEPTH (MAX_BODIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (widx[IW-1:0]),
    .wdata ({item.data.position_x, item.data.position_y, item.data.mass,
             item.data.radius, item.data.atmos_radius, item.data.drag_coeff}),
    .raddr (i[IW-1:0]),
    .rdata (rd_body)
  );

  gde_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .opa (opa),
    .opb (opb),
    .rsp (rsp)
  );

  always_comb begin
    dx_c  = {rd_body.pos_x[31], rd_body.pos_x} - {sx[31], sx};
    dy_c  = {rd_body.pos_y[31], rd_body.pos_y} - {sy[31], sy};
    adx_c = dx_c[32] ? (33'd0 - dx_c) : dx_c;
    ady_c = dy_c[32] ? (33'd0 - dy_c) : dy_c;
    sa    = {1'b0, sr} + {1'b0, rd_body.atmos};
    avx   = vx[31] ? (32'd0 - vx) : vx;
    avy   = vy[31] ? (32'd0 - vy) : vy;
    amx   = ax[61] ? 61'(-ax) : 61'(ax);
    amy   = ay[61] ? 61'(-ay) : 61'(ay);
    vxa   = avx;
    vya   = avy;
    den   = 56'((ms == 32'd0) ? 32'd1 : ms) << FRAC_BITS;
  end

  // operand selection: wait states but a chain's last launch the next operation on done (S_BRD only for a nonzero d2)
  always_comb begin
    req.start = 1'b0;
    req.op    = AR_MUL;
    req.steps = 8'd0;
    opa       = '0;
    opb       = '0;
    unique case (state)
      S_DIFF: begin
        req = '{1'b1, AR_MUL, 8'd33};
        opa = UW'(adx_c);
        opb = UW'(adx_c);
      end
      S_SQX: begin
        req = '{rsp.done, AR_MUL, 8'd33};
        opa = UW'(ady);
        opb = UW'(ady);
      end
      S_SQY: begin
        req = '{rsp.done, AR_MUL, 8'd32};
        opa = UW'(sa);
        opb = UW'(sa);
      end
      S_ATM: begin
        req = '{rsp.done, AR_MUL, 8'd31};
        opa = UW'(rd_body.radius);
        opb = UW'(rd_body.radius);
      end
      S_BRD: begin
        req = '{rsp.done && (d2 != 66'd0), AR_SQRT, 8'd33};
        opa = UW'(d2);
      end
      S_SQRT: begin
        req = '{rsp.done, AR_MUL, 8'd32};
        opa = UW'(grav_const);
        opb = UW'(rd_body.mass);
      end
      S_GM: begin
        req = '{rsp.done, AR_MUL, 8'd34};
        opa = UW'(d);
        opb = UW'(d);
      end
      S_DD: begin
        req = '{rsp.done, AR_DIV, STEP_MAG};
        opa = UW'(gm);
        opb = rsp.value;
      end
      S_MAG: begin
        req = '{rsp.done, AR_MUL, 8'd33};
        opa = rsp.value;
        opb = UW'(adx);
      end
      S_MX, S_MY: begin
        req = '{rsp.done, AR_DIV, STEP_QUO};
        opa = rsp.value;
        opb = UW'(d);
      end
      S_QX: begin
        req = '{rsp.done, AR_MUL, 8'd33};
        opa = UW'(mag);
        opb = UW'(ady);
      end
      S_DRAG: begin
        req = '{found, AR_MUL, 8'd32};
        opa = UW'(avx);
        opb = UW'(avx);
      end
      S_V2X: begin
        req = '{rsp.done, AR_MUL, 8'd32};
        opa = UW'(avy);
        opb = UW'(avy);
      end
      S_V2Y: begin
        req = '{rsp.done, AR_SQRT, 8'd32};
        opa = UW'(v2) + rsp.value;
      end
      S_SPD: begin
        req = '{rsp.done, AR_MUL, 8'd32};
        opa = UW'(avx);
        opb = rsp.value;
      end
      S_KX1, S_KY1: begin
        req = '{rsp.done, AR_MUL, 8'd32};
        opa = rsp.value;
        opb = UW'(dk);
      end
      S_KX2, S_KY2: begin
        req = '{rsp.done, AR_DIV, 8'd96};
        opa = rsp.value;
        opb = UW'(den);
      end
      S_KX3: begin
        req = '{rsp.done, AR_MUL, 8'd32};
        opa = UW'(avy);
        opb = UW'(spd);
      end
      S_DVX: begin
        req = '{1'b1, AR_MUL, 8'd24};
        opa = UW'(amx);
        opb = UW'(dt);
      end
      S_SVX: begin
        req = '{rsp.done, AR_MUL, 8'd24};
        opa = UW'(amy);
        opb = UW'(dt);
      end
      S_SVY: begin
        req = '{rsp.done, AR_MUL, 8'd24};
        opa = UW'(vxa);
        opb = UW'(dt);
      end
      S_SPX: begin
        req = '{rsp.done, AR_MUL, 8'd24};
        opa = UW'(vya);
        opb = UW'(dt);
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    upd = 33'd0;
    unique case (state)
      S_SVX:   upd = step_add(vx, rsp.value, ax[61]);
      S_SVY:   upd = step_add(vy, rsp.value, ay[61]);
      S_SPX:   upd = step_add(sx, rsp.value, vx[31]);
      S_SPY:   upd = step_add(sy, rsp.value, vy[31]);
      default: upd = 33'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bodies_in_use <= 5'd0;
      grav_const    <= 32'd65536;
    end else if (cfg.valid) begin
      if (cfg.data.index == REG_BODIES) bodies_in_use <= cfg.data.wdata[4:0];
      else grav_const <= cfg.data.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid && item.data.operation == OP_STEP) begin
            sx    <= item.data.position_x;
            sy    <= item.data.position_y;
            vx    <= item.data.velocity_x;
            vy    <= item.data.velocity_y;
            ms    <= item.data.mass;
            sr    <= item.data.radius;
            dt    <= item.data.time_step;
            last  <= item.data.last_ship;
            i     <= '0;
            ax    <= '0;
            ay    <= '0;
            found <= 1'b0;
            flag  <= 1'b0;
            state <= S_RD;
          end
        end
        S_RD: state <= (i == n_use) ? S_DRAG : S_DIFF;
        S_DIFF: begin
          adx   <= adx_c;
          ady   <= ady_c;
          dxneg <= dx_c[32];
          dyneg <= dy_c[32];
          state <= S_SQX;
        end
        S_SQX: if (rsp.done) begin
          d2    <= rsp.value[65:0];
          state <= S_SQY;
        end
        S_SQY: if (rsp.done) begin
          d2    <= d2 + rsp.value[65:0];
          state <= S_ATM;
        end
        S_ATM: if (rsp.done) begin
          atm2  <= rsp.value[63:0];
          state <= S_BRD;
        end
        S_BRD: if (rsp.done) begin
          // first atmosphere shell with nonzero drag holding the ship
          if (!found && rd_body.drag != 32'd0 && d2 < 66'(atm2) &&
              d2 > rsp.value[65:0]) begin
            found <= 1'b1;
            dk    <= rd_body.drag;
          end
          state <= (d2 == 66'd0) ? S_NEXT : S_SQRT;
        end
        S_SQRT: if (rsp.done) begin
          d     <= (rsp.value[33:0] == 34'd0) ? 34'd1 : rsp.value[33:0];
          state <= S_GM;
        end
        S_GM: if (rsp.done) begin
          gm    <= GMW'(rsp.value[63:0]) << FRAC_BITS;
          state <= S_DD;
        end
        S_DD:  if (rsp.done) state <= S_MAG;
        S_MAG: if (rsp.done) begin
          mag   <= rsp.value[GMW-1:0];
          state <= S_MX;
        end
        S_MX:  if (rsp.done) state <= S_QX;
        S_QX: if (rsp.done) begin
          ax    <= acc_add(ax, clip60(rsp.value), dxneg);
          state <= S_MY;
        end
        S_MY:  if (rsp.done) state <= S_QY;
        S_QY: if (rsp.done) begin
          ay    <= acc_add(ay, clip60(rsp.value), dyneg);
          state <= S_NEXT;
        end
        S_NEXT: begin
          i     <= i + CW'(1);
          state <= S_RD;
        end
        S_DRAG: state <= found ? S_V2X : S_DVX;
        S_V2X: if (rsp.done) begin
          v2    <= rsp.value[63:0];
          state <= S_V2Y;
        end
        S_V2Y: if (rsp.done) state <= S_SPD;
        S_SPD: if (rsp.done) begin
          spd   <= rsp.value[31:0];
          state <= S_KX1;
        end
        S_KX1: if (rsp.done) state <= S_KX2;
        S_KX2: if (rsp.done) state <= S_KX3;
        S_KX3: if (rsp.done) begin
          // drag opposes the velocity
          ax    <= acc_add(ax, clip60(rsp.value), !vx[31]);
          state <= S_KY1;
        end
        S_KY1: if (rsp.done) state <= S_KY2;
        S_KY2: if (rsp.done) state <= S_KY3;
        S_KY3: if (rsp.done) begin
          ay    <= acc_add(ay, clip60(rsp.value), !vy[31]);
          state <= S_DVX;
        end
        S_DVX: state <= S_SVX;
        S_SVX: if (rsp.done) begin
          vx    <= upd[31:0];
          flag  <= flag | upd[32];
          state <= S_SVY;
        end
        S_SVY: if (rsp.done) begin
          vy    <= upd[31:0];
          flag  <= flag | upd[32];
          state <= S_SPX;
        end
        S_SPX: if (rsp.done) begin
          sx    <= upd[31:0];
          flag  <= flag | upd[32];
          state <= S_SPY;
        end
        S_SPY: if (rsp.done) begin
          sy    <= upd[31:0];
          flag  <= flag | upd[32];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || result.ready) begin
            res_q.new_position_x <= sx;
            res_q.new_position_y <= sy;
            res_q.new_velocity_x <= vx;
            res_q.new_velocity_y <= vy;
            res_q.saturated      <= flag;
            res_q.frame_end      <= last;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the gravity and drag euler step core: self-checking against a local predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import gde_pkg::*;

  logic clk;
  logic rst;

  gde_stream_if #(.T(item_t))   item_if ();
  gde_stream_if #(.T(result_t)) result_if ();
  gde_stream_if #(.T(cfg_t))    cfg_if ();

  gravity_drag_euler_step_core DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  localparam longint ACC_LIM = 64'sd1 << 60;
  localparam longint DV_LIM  = 64'sd1 << 40;
  localparam int     TBL     = DEF_MAX_BODIES;

  // predictor copy of the table and registers
  body_t       body_tbl [TBL];
  logic [4:0]  bodies_used;
  logic [31:0] grav_k;

  result_t expected_q [$];
  int          error_count;
  bit          send_busy_mode;
  bit          recv_busy_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [127:0] isqrt_floor(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint clip_term(logic [127:0] m, bit neg);
    longint v;
    v = (m > 128'(ACC_LIM)) ? ACC_LIM : longint'(m[63:0]);
    return neg ? -v : v;
  endfunction

  function automatic longint accel_add(longint a, longint t);
    longint s;
    s = a + t;
    if (s > ACC_LIM) return ACC_LIM;
    if (s < -ACC_LIM) return -ACC_LIM;
    return s;
  endfunction

  function automatic longint step_scale(longint v, logic [23:0] dt);
    logic [127:0] m;
    logic [127:0] p;
    longint       q;
    m = (v < 0) ? 128'(-v) : 128'(v);
    p = (m * 128'(dt)) >> DEF_FRAC_BITS;
    q = (p > 128'(DV_LIM)) ? DV_LIM : longint'(p[63:0]);
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint clamp32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic result_t euler_step_predict(item_t it);
    result_t      r;
    longint       ax, ay, dx, dy, vx, vy, sx, sy, px, py;
    logic [127:0] adx, ady, d2, d, mag, sa, rr, avx, avy, spd, den, drag_k, gm;
    int           n;
    bit           found, flag;
    ax = 0;
    ay = 0;
    found = 1'b0;
    flag = 1'b0;
    drag_k = '0;
    sx = longint'(it.position_x);
    sy = longint'(it.position_y);
    vx = longint'(it.velocity_x);
    vy = longint'(it.velocity_y);
    n = (bodies_used > TBL) ? TBL : int'(bodies_used);
    for (int i = 0; i < n; i++) begin
      dx = longint'($signed(body_tbl[i].pos_x)) - sx;
      dy = longint'($signed(body_tbl[i].pos_y)) - sy;
      adx = (dx < 0) ? 128'(-dx) : 128'(dx);
      ady = (dy < 0) ? 128'(-dy) : 128'(dy);
      d2 = adx * adx + ady * ady;
      sa = 128'(it.radius) + 128'(body_tbl[i].atmos);
      rr = 128'(body_tbl[i].radius);
      if (!found && body_tbl[i].drag != 0 && d2 < sa * sa && d2 > rr * rr) begin
        found = 1'b1;
        drag_k = 128'(body_tbl[i].drag);
      end
      // coincident ship and body: no pull
      if (d2 == 0) continue;
      d = isqrt_floor(d2);
      if (d == 0) d = 1;
      gm = 128'(grav_k) * 128'(body_tbl[i].mass);
      mag = (gm << DEF_FRAC_BITS) / (d * d);
      ax = accel_add(ax, clip_term(mag * adx / d, dx < 0));
      ay = accel_add(ay, clip_term(mag * ady / d, dy < 0));
    end
    if (found) begin
      avx = (vx < 0) ? 128'(-vx) : 128'(vx);
      avy = (vy < 0) ? 128'(-vy) : 128'(vy);
      spd = isqrt_floor(avx * avx + avy * avy);
      den = 128'((it.mass == 0) ? 32'd1 : it.mass) << DEF_FRAC_BITS;
      // drag opposes the velocity
      ax = accel_add(ax, clip_term(avx * spd * drag_k / den, vx >= 0));
      ay = accel_add(ay, clip_term(avy * spd * drag_k / den, vy >= 0));
    end
    vx = clamp32(vx + step_scale(ax, it.time_step), flag);
    vy = clamp32(vy + step_scale(ay, it.time_step), flag);
    px = clamp32(sx + step_scale(vx, it.time_step), flag);
    py = clamp32(sy + step_scale(vy, it.time_step), flag);
    r.new_position_x = px[31:0];
    r.new_position_y = py[31:0];
    r.new_velocity_x = vx[31:0];
    r.new_velocity_y = vy[31:0];
    r.saturated = flag;
    r.frame_end = it.last_ship;
    return r;
  endfunction

  function automatic item_t body_item(logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] m, logic [30:0] rad, logic [30:0] atm,
                                      logic [31:0] k);
    item_t it;
    it = '0;
    it.operation = OP_LOAD;
    it.body_index = idx;
    it.position_x = x;
    it.position_y = y;
    it.mass = m;
    it.radius = rad;
    it.atmos_radius = atm;
    it.drag_coeff = k;
    it.velocity_x = $urandom;
    it.velocity_y = $urandom;
    it.time_step = $urandom;
    it.last_ship = $urandom;
    return it;
  endfunction

  function automatic item_t ship_item(logic [31:0] x, logic [31:0] y, logic [31:0] vx,
                                      logic [31:0] vy, logic [31:0] m, logic [30:0] rad,
                                      logic [23:0] dt, logic last);
    item_t it;
    it.operation = OP_STEP;
    it.body_index = $urandom;
    it.position_x = x;
    it.position_y = y;
    it.velocity_x = vx;
    it.velocity_y = vy;
    it.mass = m;
    it.radius = rad;
    it.atmos_radius = $urandom;
    it.drag_coeff = $urandom;
    it.time_step = dt;
    it.last_ship = last;
    return it;
  endfunction

  // values biased toward the corners of a 32-bit field
  function automatic logic [31:0] edgy32();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      4, 5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      6: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_dt();
    case ($urandom_range(0, 5))
      0: return 24'hff_ffff;
      1: return 24'h00_0000;
      2, 3: return 24'($urandom_range(1, 32'h1_0000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    logic [31:0] m;
    m = edgy32();
    return (m == 0) ? 32'd1 : m;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = send_busy_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data <= it;
    forever begin
      @(posedge clk);
      if (item_if.ready) break;
    end
    if (it.operation == OP_LOAD) body_tbl[it.body_index] = '{it.position_x, it.position_y,
        it.mass, it.radius, it.atmos_radius, it.drag_coeff};
    else expected_q.push_back(euler_step_predict(it));
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // a body load may still be finishing
    repeat (50) @(posedge clk);
  endtask

  task automatic write_registers(logic [4:0] bodies, logic [31:0] g);
    cfg_t c;
    wait_drained();
    c.index = REG_BODIES;
    c.wdata = 32'(bodies);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= c;
    forever begin
      @(posedge clk);
      if (cfg_if.ready) break;
    end
    bodies_used = bodies;
    c.index = REG_GRAV;
    c.wdata = g;
    cfg_if.data <= c;
    forever begin
      @(posedge clk);
      if (cfg_if.ready) break;
    end
    grav_k = g;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // result side: random stalls, compare each beat with the oldest expectation
  initial begin
    result_t got, want;
    int      stall;
    result_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = recv_busy_mode ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (result_if.ready && result_if.valid) break;
      end
      got = result_if.data;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("new_position_x", want.new_position_x, got.new_position_x);
        check_field("new_position_y", want.new_position_y, got.new_position_y);
        check_field("new_velocity_x", want.new_velocity_x, got.new_velocity_x);
        check_field("new_velocity_y", want.new_velocity_y, got.new_velocity_y);
        check_field("saturated", want.saturated, got.saturated);
        check_field("frame_end", want.frame_end, got.frame_end);
      end
    end
  end

  task automatic test_body_table();
    // no bodies in use yet: pure velocity integration
    send_item(ship_item(32'h0001_0000, 32'hffff_0000, 32'h0003_0000, 32'hfffd_0000,
                        32'h0001_0000, 31'h0001_0000, 24'h01_0000, 1'b1));
    send_item(body_item(4'd0, 32'd0, 32'd0, 32'h0064_0000, 31'h000a_0000, 31'h0032_0000,
                        32'h0001_0000));
    send_item(body_item(4'd1, 32'h03e8_0000, 32'd0, 32'h0001_0000, 31'h0001_0000,
                        31'h7fff_ffff, 32'd0));
    send_item(body_item(4'd2, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 31'h7fff_ffff,
                        31'h7fff_ffff, 32'hffff_ffff));
    for (int i = 3; i < TBL; i++)
      send_item(body_item(4'(i), edgy32(), edgy32(), pick_mass(), 31'($urandom),
                          31'($urandom), edgy32()));
  endtask

  task automatic test_special_steps();
    write_registers(5'd3, 32'h0001_0000);
    // inside the atmosphere of the first body
    send_item(ship_item(32'h0014_0000, 32'd0, 32'h0005_0000, 32'h0003_0000,
                        32'h0002_0000, 31'h0001_0000, 24'h00_4000, 1'b0));
    // on top of a zero-drag body
    send_item(ship_item(32'h03e8_0000, 32'd0, 32'hfff0_0000, 32'd0,
                        32'hffff_ffff, 31'd0, 24'h00_8000, 1'b0));
    // below the first body's surface: no drag
    send_item(ship_item(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
                        32'd1, 31'd0, 24'hff_ffff, 1'b0));
    // zero time step
    send_item(ship_item(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        32'd1, 31'h7fff_ffff, 24'd0, 1'b1));
  endtask

  task automatic test_register_extremes();
    write_registers(5'd31, 32'hffff_ffff);
    send_item(ship_item(32'h0000_8000, 32'hffff_8000, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h0001_0000, 31'h7fff_ffff, 24'hff_ffff, 1'b1));
    write_registers(5'd16, 32'd0);
    send_item(ship_item(32'h0010_0000, 32'h0010_0000, 32'h0001_0000, 32'd0,
                        32'h0001_0000, 31'h0001_0000, 24'h01_0000, 1'b1));
  endtask

  task automatic test_random_traffic();
    logic [4:0]  nb;
    logic [31:0] g;
    int          cnt, k;
    item_t       it;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: nb = 5'd16;
        1: nb = 5'd0;
        default: nb = 5'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 4))
        0: g = 32'hffff_ffff;
        1: g = 32'd0;
        default: g = $urandom_range(1, 32'h0010_0000);
      endcase
      write_registers(nb, g);
      send_busy_mode = (ph % 3 == 1);
      recv_busy_mode = (ph % 4 == 2);
      cnt = (nb > 4) ? 20 : 80;
      for (int j = 0; j < cnt; j++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(body_item(4'($urandom), edgy32(), edgy32(), pick_mass(), 31'(edgy32()),
                              31'(edgy32()), edgy32()));
        end else begin
          it = ship_item(edgy32(), edgy32(), edgy32(), edgy32(), pick_mass(), 31'(edgy32()),
                         pick_dt(), 1'($urandom));
          if (nb != 0 && $urandom_range(0, 1)) begin
            // place the ship near a body in use so shells and drag come into play
            k = $urandom_range(0, (nb > TBL ? TBL : nb) - 1);
            it.position_x = body_tbl[k].pos_x + 32'($signed($urandom_range(0, 32'h0040_0000))
                            - 32'sh0020_0000);
            it.position_y = body_tbl[k].pos_y + 32'($signed($urandom_range(0, 32'h0040_0000))
                            - 32'sh0020_0000);
            it.radius = 31'($urandom_range(0, 32'h0010_0000));
          end
          send_item(it);
        end
      end
      send_busy_mode = 1'b0;
      recv_busy_mode = 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    error_count = 0;
    send_busy_mode = 1'b0;
    recv_busy_mode = 1'b0;
    bodies_used = '0;
    grav_k = 32'h0001_0000;
    foreach (body_tbl[i]) body_tbl[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_body_table();
    test_special_steps();
    test_register_extremes();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/gde_pkg.sv
hw/rtl/gde_stream_if.sv
hw/rtl/gde_ram.sv
hw/rtl/gde_arith.sv
hw/rtl/gravity_drag_euler_step_core.sv
tb/tb_top.sv
